### rtl/core/sbr_pkg.sv
`timescale 1ns / 1ps

package sbr_pkg;

  // Frame geometry
  localparam int CHANNELS    = 8;
  localparam int CH_W        = 11;
  localparam int FRAME_BYTES = 25;
  localparam int PAYLOAD_LEN = FRAME_BYTES - 2;
  localparam int PAY_IDX_W   = $clog2(PAYLOAD_LEN);
  localparam int PAY_CNT_W   = $clog2(PAYLOAD_LEN + 1);
  localparam int CH_CNT_W    = $clog2(CHANNELS);
  localparam int RUN_W       = CHANNELS * CH_W;

  // Run queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Flag byte masks
  localparam logic [7:0] FLAG_LOST     = 8'h04;
  localparam logic [7:0] FLAG_FAILSAFE = 8'h08;

  // Item function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Cause codes
  localparam logic [1:0] CAUSE_GOOD     = 2'd0;
  localparam logic [1:0] CAUSE_FAILSAFE = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT  = 2'd2;

  // Register map
  localparam int          PADDR_W        = 4;
  localparam logic [1:0] REG_START      = 2'd0;
  localparam logic [1:0] REG_END        = 2'd1;
  localparam logic [1:0] REG_IDLE_LIM   = 2'd2;
  localparam logic [1:0] REG_FSAFE_LIM  = 2'd3;

  localparam logic [7:0] START_RST      = 8'd15;
  localparam logic [7:0] END_RST        = 8'd0;
  localparam logic [7:0] IDLE_LIM_RST   = 8'd2;
  localparam logic [7:0] FSAFE_LIM_RST  = 8'd64;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_value;
  } sbr_in_t;

  typedef struct packed {
    logic [2:0]      channel_index;
    logic [CH_W-1:0] channel_value;
    logic [1:0]      cause;
    logic            last;
  } sbr_out_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] idle_tick_limit;
    logic [7:0] failsafe_tick_limit;
  } sbr_cfg_t;

  typedef struct packed {
    logic [RUN_W-1:0] chans;
    logic [1:0]       cause;
  } sbr_run_t;

endpackage

### rtl/core/sbus_frame_receiver.sv
`timescale 1ns / 1ps
// Input: one item per cycle; the front decides framing and supervisor actions in the
// accepting cycle and stalls only when the two-run queue is full.
// A closing byte or tick stores its run in the queue; the back sequencer loads it when free.
// Output: one channel per cycle unless stalled, eight channels per run, set by the back sequencer.
// Reset: framing, counters, queue and output clear; registers return to defaults;
// the payload store is not cleared.
module sbus_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sbr_pkg::sbr_in_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sbr_pkg::sbr_out_t           out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sbr_pkg::*;

  sbr_cfg_t cfg;
  sbr_run_t push_run, pop_run;
  logic     push, pop, q_full, q_valid;

  // Configuration registers
  sbr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Framing and supervisor
  sbr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .push_run_o (push_run),
    .q_full_i   (q_full)
  );

  // Run queue
  sbr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_run_o  (pop_run)
  );

  // Channel emitter
  sbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_run_i     (pop_run),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/core/sbr_regs.sv
`timescale 1ns / 1ps

module sbr_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [sbr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output sbr_pkg::sbr_cfg_t       cfg_o
);
  import sbr_pkg::*;

  sbr_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_START:     cfg_d.start_byte          = pwdata[7:0];
        REG_END:       cfg_d.end_byte            = pwdata[7:0];
        REG_IDLE_LIM:  cfg_d.idle_tick_limit     = pwdata[7:0];
        REG_FSAFE_LIM: cfg_d.failsafe_tick_limit = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte          <= START_RST;
      cfg_q.end_byte            <= END_RST;
      cfg_q.idle_tick_limit     <= IDLE_LIM_RST;
      cfg_q.failsafe_tick_limit <= FSAFE_LIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_START:     prdata = {24'd0, cfg_q.start_byte};
      REG_END:       prdata = {24'd0, cfg_q.end_byte};
      REG_IDLE_LIM:  prdata = {24'd0, cfg_q.idle_tick_limit};
      REG_FSAFE_LIM: prdata = {24'd0, cfg_q.failsafe_tick_limit};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/sbr_front.sv
`timescale 1ns / 1ps

module sbr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbr_pkg::sbr_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbr_pkg::sbr_in_t  in_item_i,
  output logic              push_o,
  output sbr_pkg::sbr_run_t push_run_o,
  input  logic              q_full_i
);
  import sbr_pkg::*;

  logic                 in_frame_q, in_frame_d;
  logic [PAY_CNT_W-1:0] count_q, count_d;
  logic [7:0]           idle_q, idle_d;
  logic [7:0]           age_q, age_d;
  logic [7:0]           store_q [PAYLOAD_LEN];
  logic                 store_we;
  logic [8*PAYLOAD_LEN-1:0] pay_flat;
  logic [RUN_W-1:0]     chan_vec;
  logic [7:0]           flags;
  logic [7:0]           idle_inc, age_inc;
  logic                 accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Flatten the payload bytes little-endian; channels sit at fixed bit slices.
  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      pay_flat[8*i +: 8] = store_q[i];
    end
  end

  assign chan_vec = pay_flat[RUN_W-1:0];
  assign flags    = store_q[PAYLOAD_LEN-1];
  assign idle_inc = idle_q + 8'd1;
  assign age_inc  = age_q + 8'd1;

  // Classify the item and update the framing and supervisor state.
  always_comb begin
    in_frame_d       = in_frame_q;
    count_d          = count_q;
    idle_d           = idle_q;
    age_d            = age_q;
    store_we         = 1'b0;
    push_o           = 1'b0;
    push_run_o.chans = chan_vec;
    push_run_o.cause = CAUSE_GOOD;
    if (accept) begin
      if (in_item_i.func == FUNC_BYTE) begin
        idle_d = 8'd0;
        if (!in_frame_q) begin
          if (in_item_i.byte_value == cfg_i.start_byte) begin
            count_d    = '0;
            in_frame_d = 1'b1;
          end
        end else if (count_q < PAY_CNT_W'(PAYLOAD_LEN)) begin
          store_we = 1'b1;
          count_d  = count_q + PAY_CNT_W'(1);
        end else begin
          // Closing byte: a wrong one or a lost frame is dropped, failsafe zeroes the channels.
          if (in_item_i.byte_value == cfg_i.end_byte) begin
            if ((flags & FLAG_LOST) != 8'd0) begin
              push_o = 1'b0;
            end else if ((flags & FLAG_FAILSAFE) != 8'd0) begin
              push_o           = 1'b1;
              push_run_o.chans = '0;
              push_run_o.cause = CAUSE_FAILSAFE;
            end else begin
              push_o = 1'b1;
              age_d  = 8'd0;
            end
          end
          in_frame_d = 1'b0;
        end
      end else begin
        // Supervisor tick: idle timeout drops sync, frame age timeout zeroes.
        if (idle_inc > cfg_i.idle_tick_limit) begin
          idle_d     = 8'd0;
          in_frame_d = 1'b0;
        end else begin
          idle_d = idle_inc;
        end
        if (age_inc > cfg_i.failsafe_tick_limit) begin
          age_d            = 8'd0;
          push_o           = 1'b1;
          push_run_o.chans = '0;
          push_run_o.cause = CAUSE_TIMEOUT;
        end else begin
          age_d = age_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      idle_q     <= 8'd0;
      age_q      <= 8'd0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      idle_q     <= idle_d;
      age_q      <= age_d;
    end
  end

  // Payload bytes, written in arrival order.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[PAY_IDX_W-1:0]] <= in_item_i.byte_value;
    end
  end

endmodule

### rtl/core/sbr_queue.sv
`timescale 1ns / 1ps

module sbr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sbr_pkg::sbr_run_t push_run_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sbr_pkg::sbr_run_t pop_run_o
);
  import sbr_pkg::*;

  sbr_run_t           ent_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o    = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_run_o = ent_q[rd_ptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_run_i;
    end
  end

endmodule

### rtl/core/sbr_back.sv
`timescale 1ns / 1ps

module sbr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  sbr_pkg::sbr_run_t q_run_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sbr_pkg::sbr_out_t out_item_o
);
  import sbr_pkg::*;

  logic                active_q;
  logic [CH_CNT_W-1:0] ch_q;
  logic [RUN_W-1:0]    vec_q;
  logic [1:0]          cause_q;
  logic                last_ch;
  logic                out_acc;

  assign last_ch = (ch_q == CH_CNT_W'(CHANNELS - 1));
  assign out_acc = active_q & ~out_stall_i;
  assign q_pop_o = q_valid_i & (~active_q | (out_acc & last_ch));

  // Channel sequencer: one channel per accepted item, next run follows directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ch_q     <= '0;
    end else if (q_pop_o) begin
      active_q <= 1'b1;
      ch_q     <= '0;
    end else if (out_acc) begin
      if (last_ch) begin
        active_q <= 1'b0;
      end else begin
        ch_q <= ch_q + CH_CNT_W'(1);
      end
    end
  end

  // Channel values shift down as each one is taken.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      vec_q   <= q_run_i.chans;
      cause_q <= q_run_i.cause;
    end else if (out_acc) begin
      vec_q <= vec_q >> CH_W;
    end
  end

  assign out_valid_o              = active_q;
  assign out_item_o.channel_index = 3'(ch_q);
  assign out_item_o.channel_value = vec_q[CH_W-1:0];
  assign out_item_o.cause         = cause_q;
  assign out_item_o.last          = last_ch;

endmodule

### rtl/core/sbr_checker.sv
`timescale 1ns / 1ps

module sbr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sbr_pkg::sbr_out_t out_item_o,
  input logic              pready
);
  import sbr_pkg::*;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // The last flag marks exactly the final channel of a run.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last == (out_item_o.channel_index == 3'(CHANNELS - 1))))
    else $error("last flag does not match channel index");

  // Within a run the channels follow one another with the same cause.
  a_run_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last |=>
      out_valid_o && out_item_o.channel_index == 3'($past(out_item_o.channel_index) + 3'd1)
      && out_item_o.cause == $past(out_item_o.cause))
    else $error("run sequence broken");

  // Failsafe and timeout runs carry zero channels.
  a_zero_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.cause == CAUSE_FAILSAFE || out_item_o.cause == CAUSE_TIMEOUT)
      |-> out_item_o.channel_value == '0)
    else $error("zeroed run carries a nonzero value");

  // Once reset has been applied, nothing is offered.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && pready)
    else $error("output active during reset");

endmodule

bind sbus_frame_receiver sbr_checker u_sbr_checker (.*);

### test/sbus_frame_receiver_check.sv
`timescale 1ns / 1ps

module sbus_frame_receiver_check
  import sbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sbr_in_t             in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sbr_out_t            out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [PADDR_W-1:0]  paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  input  logic                end_of_test_i,
  output int                  mismatch_o,
  output int                  pending_o,
  output int                  channels_o,
  output int                  good_runs_o,
  output int                  failsafe_runs_o,
  output int                  timeout_runs_o
);

  // Shadow copy of the registers and of the receiver state.
  sbr_cfg_t             cfg;
  logic                 in_frame;
  logic [PAY_CNT_W-1:0] pay_cnt;
  logic [7:0]           payload [PAYLOAD_LEN];
  logic [7:0]           idle_cnt;
  logic [7:0]           age_cnt;

  // Channels predicted but not yet seen at the output, oldest first.
  sbr_out_t pending_channels[$];
  sbr_out_t oldest;
  logic [7:0] reg_now;
  logic leftover_done;

  int mismatches;
  int channels;
  int good_runs;
  int failsafe_runs;
  int timeout_runs;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Queue one run of channels, either unpacked from the payload or cleared.
  task automatic queue_run(input logic zero, input logic [1:0] cause);
    logic [RUN_W-1:0] bits;
    sbr_out_t ch;
    for (int i = 0; i < RUN_W / 8; i++) begin
      bits[8*i +: 8] = payload[i];
    end
    for (int c = 0; c < CHANNELS; c++) begin
      ch.channel_index = 3'(c);
      ch.channel_value = zero ? '0 : bits[CH_W*c +: CH_W];
      ch.cause         = cause;
      ch.last          = (c == CHANNELS - 1);
      pending_channels.push_back(ch);
    end
    case (cause)
      CAUSE_GOOD:     good_runs++;
      CAUSE_FAILSAFE: failsafe_runs++;
      default:        timeout_runs++;
    endcase
  endtask

  // Advance the receiver by one accepted item.
  task automatic advance_receiver(input sbr_in_t it);
    logic [7:0] flags;
    if (it.func == FUNC_BYTE) begin
      idle_cnt = '0;
      if (!in_frame) begin
        if (it.byte_value == cfg.start_byte) begin
          pay_cnt  = '0;
          in_frame = 1'b1;
        end
      end else if (pay_cnt < PAYLOAD_LEN) begin
        payload[pay_cnt] = it.byte_value;
        pay_cnt = pay_cnt + 1'b1;
      end else begin
        // The byte after the payload always closes the frame.
        flags = payload[PAYLOAD_LEN-1];
        if (it.byte_value == cfg.end_byte) begin
          if ((flags & FLAG_LOST) != 0) begin
            // A lost frame changes nothing.
          end else if ((flags & FLAG_FAILSAFE) != 0) begin
            queue_run(1'b1, CAUSE_FAILSAFE);
          end else begin
            queue_run(1'b0, CAUSE_GOOD);
            age_cnt = '0;
          end
        end
        in_frame = 1'b0;
      end
    end else begin
      // Supervisor tick: both counters count up, then compare.
      idle_cnt = idle_cnt + 8'd1;
      if (idle_cnt > cfg.idle_tick_limit) begin
        idle_cnt = '0;
        in_frame = 1'b0;
      end
      age_cnt = age_cnt + 8'd1;
      if (age_cnt > cfg.failsafe_tick_limit) begin
        age_cnt = '0;
        queue_run(1'b1, CAUSE_TIMEOUT);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.start_byte          = START_RST;
      cfg.end_byte            = END_RST;
      cfg.idle_tick_limit     = IDLE_LIM_RST;
      cfg.failsafe_tick_limit = FSAFE_LIM_RST;
      in_frame      = 1'b0;
      pay_cnt       = '0;
      idle_cnt      = '0;
      age_cnt       = '0;
      leftover_done = 1'b0;
      mismatches    = 0;
      channels      = 0;
      good_runs     = 0;
      failsafe_runs = 0;
      timeout_runs  = 0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        payload[i] = '0;
      end
      pending_channels.delete();
    end else begin
      // Output side first: a result never comes in the cycle of its cause.
      if (out_valid_i && !out_stall_i) begin
        if (pending_channels.size() == 0) begin
          report_mismatch($sformatf("channel %0d value %0d cause %0d with no run pending",
                                    out_item_i.channel_index, out_item_i.channel_value,
                                    out_item_i.cause));
        end else begin
          oldest = pending_channels.pop_front();
          channels++;
          if (out_item_i.channel_index !== oldest.channel_index ||
              out_item_i.channel_value !== oldest.channel_value ||
              out_item_i.cause !== oldest.cause || out_item_i.last !== oldest.last) begin
            report_mismatch($sformatf(
              "index/value/cause/last expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
              oldest.channel_index, oldest.channel_value, oldest.cause, oldest.last,
              out_item_i.channel_index, out_item_i.channel_value, out_item_i.cause,
              out_item_i.last));
          end
        end
      end

      // Register accesses: track writes, check read data.
      if (psel_i && penable_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_START:    reg_now = cfg.start_byte;
          REG_END:      reg_now = cfg.end_byte;
          REG_IDLE_LIM: reg_now = cfg.idle_tick_limit;
          default:      reg_now = cfg.failsafe_tick_limit;
        endcase
        if (pwrite_i) begin
          case (paddr_i[PADDR_W-1:2])
            REG_START:    cfg.start_byte          = pwdata_i[7:0];
            REG_END:      cfg.end_byte            = pwdata_i[7:0];
            REG_IDLE_LIM: cfg.idle_tick_limit     = pwdata_i[7:0];
            default:      cfg.failsafe_tick_limit = pwdata_i[7:0];
          endcase
        end else if (prdata_i !== {24'd0, reg_now}) begin
          report_mismatch($sformatf("register at 0x%0h read 0x%0h, expected 0x%0h",
                                    paddr_i, prdata_i, reg_now));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        advance_receiver(in_item_i);
      end

      if (end_of_test_i && !leftover_done) begin
        leftover_done = 1'b1;
        if (pending_channels.size() != 0) begin
          report_mismatch($sformatf("%0d channels never arrived", pending_channels.size()));
        end
      end
    end

    // Published once per edge so the stimulus side reads settled values.
    mismatch_o      <= mismatches;
    pending_o       <= pending_channels.size();
    channels_o      <= channels;
    good_runs_o     <= good_runs;
    failsafe_runs_o <= failsafe_runs;
    timeout_runs_o  <= timeout_runs;
  end

endmodule

### test/sbus_frame_receiver_test.sv
`timescale 1ns / 1ps

module sbus_frame_receiver_test;
  import sbr_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sbr_in_t             in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sbr_out_t            out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                end_of_test = 1'b0;

  int mismatches;
  int pending;
  int channels;
  int good_runs;
  int failsafe_runs;
  int timeout_runs;

  // Stimulus controls and bookkeeping.
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         items_sent = 0;
  sbr_cfg_t   cfg_now;
  logic [7:0] frame_pay [PAYLOAD_LEN];

  sbus_frame_receiver uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sbus_frame_receiver_check checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_i      (out_item),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .end_of_test_i   (end_of_test),
    .mismatch_o      (mismatches),
    .pending_o       (pending),
    .channels_o      (channels),
    .good_runs_o     (good_runs),
    .failsafe_runs_o (failsafe_runs),
    .timeout_runs_o  (timeout_runs)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure at the current stall rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Present one item after a random gap and hold it until accepted.
  task automatic send_item(input logic func, input logic [7:0] value);
    sbr_in_t it;
    it.func       = func;
    it.byte_value = value;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_item(FUNC_BYTE, value);
  endtask

  // The byte field of a tick is ignored, so it carries noise.
  task automatic send_tick();
    send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  // One frame from the payload buffer, with ticks slipped in at random.
  task automatic send_frame(input logic [7:0] close_byte, input int tick_pct);
    send_byte(cfg_now.start_byte);
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_byte(frame_pay[k]);
    end
    if ($urandom_range(0, 99) < tick_pct) send_tick();
    send_byte(close_byte);
  endtask

  task automatic fill_payload(input logic [7:0] data, input logic [7:0] flags);
    for (int k = 0; k < PAYLOAD_LEN - 1; k++) begin
      frame_pay[k] = data;
    end
    frame_pay[PAYLOAD_LEN-1] = flags;
  endtask

  // Register write over the APB port, then read it back.
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
    case (idx)
      REG_START:    cfg_now.start_byte          = value;
      REG_END:      cfg_now.end_byte            = value;
      REG_IDLE_LIM: cfg_now.idle_tick_limit     = value;
      default:      cfg_now.failsafe_tick_limit = value;
    endcase
    for (int rd = 0; rd < 2; rd++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (rd == 0);
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= {24'd0, value};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic apply_settings(input logic [7:0] start_b, input logic [7:0] end_b,
                                input logic [7:0] idle_lim, input logic [7:0] fsafe_lim);
    cfg_write(REG_START, start_b);
    cfg_write(REG_END, end_b);
    cfg_write(REG_IDLE_LIM, idle_lim);
    cfg_write(REG_FSAFE_LIM, fsafe_lim);
  endtask

  // Wait until every predicted channel is out, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content and flags, some noise,
  // then a burst of ticks that is now and then long enough to time out.
  task automatic random_chunk();
    logic [7:0] flags;
    logic [7:0] close_byte;
    int         n;
    if ($urandom_range(0, 99) < 75) begin
      for (int k = 0; k < PAYLOAD_LEN - 1; k++) begin
        frame_pay[k] = 8'($urandom_range(0, 255));
      end
      flags = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: flags = flags & ~(FLAG_LOST | FLAG_FAILSAFE);
        5, 6:          flags = (flags & ~FLAG_LOST) | FLAG_FAILSAFE;
        7:             flags = (flags | FLAG_LOST) & ~FLAG_FAILSAFE;
        8:             flags = flags | FLAG_LOST | FLAG_FAILSAFE;
        default:       ;
      endcase
      frame_pay[PAYLOAD_LEN-1] = flags;
      close_byte = cfg_now.end_byte;
      if ($urandom_range(0, 99) < 15) begin
        close_byte = close_byte ^ 8'($urandom_range(1, 255));
      end
      send_frame(close_byte, 4);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
    repeat (n) send_tick();
  endtask

  initial begin
    int phase_start;

    cfg_now.start_byte          = START_RST;
    cfg_now.end_byte            = END_RST;
    cfg_now.idle_tick_limit     = IDLE_LIM_RST;
    cfg_now.failsafe_tick_limit = FSAFE_LIM_RST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings.
    send_tick();
    send_byte(8'h00);
    send_byte(8'hff);
    // Full-scale channels.
    fill_payload(8'hff, 8'h00);
    send_frame(cfg_now.end_byte, 0);
    // Failsafe flag zeroes the channels.
    fill_payload(8'hff, FLAG_FAILSAFE);
    send_frame(cfg_now.end_byte, 0);
    // Lost and failsafe together: lost wins, nothing comes out.
    fill_payload(8'h5a, FLAG_LOST | FLAG_FAILSAFE);
    send_frame(cfg_now.end_byte, 0);
    // Wrong closing byte drops the frame.
    fill_payload(8'ha5, 8'h00);
    send_frame(~cfg_now.end_byte, 0);
    // Ticks in the middle of a frame lose sync; the rest is hunted over.
    send_byte(cfg_now.start_byte);
    repeat (5) send_byte(8'h3c);
    repeat (3) send_tick();
    repeat (3) send_byte(8'h81);
    drain();

    // Random phases, each with its own register settings and its own mix of input gaps and output stalls.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          apply_settings(8'h00, 8'hff, 8'd254, 8'd0);
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          apply_settings(8'hff, 8'h00, 8'd0, 8'd3);
          idle_pct = 63;
          stall_pct <= 0;
        end
        2: begin
          apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(1, 8)), 8'($urandom_range(4, 30)));
          idle_pct = 0;
          stall_pct <= 63;
        end
        default: begin
          apply_settings(8'ha5, 8'h5a, 8'd3, 8'd254);
          idle_pct = 23;
          stall_pct <= 23;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 25) begin
        random_chunk();
      end
      drain();
    end

    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d items over five register settings and four idling mixes.",
             items_sent);
    $display("Checked %0d channels: %0d good-frame, %0d failsafe and %0d timeout runs.",
             channels, good_runs, failsafe_runs, timeout_runs);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Run timed out with %0d channels still expected.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
